// ===== sv/ipdr_pkg.sv =====
// Shared types and constants for the +IPD frame receiver.
package ipdr_pkg;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_PAY  = 2'd2,
      PH_DISC = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD     = 2'd0,
      KIND_FRAME_END   = 2'd1,
      KIND_PROTO_ERR   = 2'd2,
      KIND_HDR_TIMEOUT = 2'd3
   } kind_type;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [1:0] CSR_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT  = 2'd1;
   localparam logic [1:0] CSR_GRACE    = 2'd2;

   localparam logic [10:0] CAPACITY_RESET = 11'd1024;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd200;
   localparam logic [15:0] GRACE_RESET    = 16'd1000;

   // "+IPD," with the first character at index 0
   localparam logic [4:0][7:0] HDR_PATTERN = {8'h2C, 8'h44, 8'h50, 8'h49, 8'h2B};
   localparam logic [7:0]  CHAR_COLON   = 8'h3A;
   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [7:0]  CHAR_NINE    = 8'h39;
   localparam logic [2:0]  WINDOW_LEN   = 3'd5;
   localparam logic [19:0] LENGTH_MAX   = 20'd65535;
   localparam logic [16:0] ELAPSED_MAX  = 17'd131071;

   typedef struct packed {
      logic [10:0] capacity;
      logic [15:0] timeout_ticks;
      logic [15:0] grace_ticks;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [7:0]  data;
      logic        frame_end;
      logic [10:0] delivered;
   } result_type;

endpackage

// ===== sv/ipd_frame_receiver_top.sv =====
// Top level of the +IPD frame receiver: stream ports and result register.
// A result is registered and appears on rsp_ in the cycle after its word is accepted on req_.
// Throughput: one word per cycle; the only stall is a full result register
// whose word is not taken by rsp_tready in the same cycle.
// Reset (synchronous, active high) restarts the header hunt, clears all counts,
// empties the result register and loads capacity 1024, timeout 200, grace 1000.
module ipd_frame_receiver_top
   import ipdr_pkg::*;
#(
   parameter int MAX_CAPACITY = 1024
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] data, [18:8] delivered, [23:19] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg;
   result_type res;
   result_type out_ff, out_in;
   logic       req_fire;

   assign req_tready = !out_ff.valid || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   ipdr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ipdr_core #(
      .MAX_CAPACITY (MAX_CAPACITY)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (req_fire),
      .step_cmd   (req_tuser),
      .step_byte  (req_tdata),
      .cfg        (cfg),
      .res        (res)
   );

   // load on accept, drop once taken
   always_comb begin
      out_in = out_ff;
      if (req_fire) begin
         out_in = res;
      end else if (rsp_tready) begin
         out_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tdata  = {5'b0, out_ff.delivered, out_ff.data};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.frame_end;

endmodule

// ===== sv/ipdr_csr.sv =====
// Configuration registers of the frame receiver.
module ipdr_csr
   import ipdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY: cfg_in.capacity      = csr_wdata[10:0];
            CSR_TIMEOUT:  cfg_in.timeout_ticks = csr_wdata;
            CSR_GRACE:    cfg_in.grace_ticks   = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity      <= CAPACITY_RESET;
         cfg_ff.timeout_ticks <= TIMEOUT_RESET;
         cfg_ff.grace_ticks   <= GRACE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/ipdr_core.sv =====
// Frame parser state and the single-pass update for one word.
module ipdr_core
   import ipdr_pkg::*;
#(
   parameter int MAX_CAPACITY = 1024
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_valid,
   input  logic       step_cmd,
   input  logic [7:0] step_byte,
   input  cfg_type    cfg,
   output result_type res
);

   localparam logic [16:0] MAX_CAP_W = 17'(MAX_CAPACITY);

   phase_type        phase_ff, phase_in;
   logic [4:0][7:0]  window_ff, window_in;
   logic [2:0]       window_fill_ff, window_fill_in;
   logic [15:0]      length_accum_ff, length_accum_in;
   logic             digit_seen_ff, digit_seen_in;
   logic [15:0]      consumed_ff, consumed_in;
   logic [10:0]      delivered_ff, delivered_in;
   logic [16:0]      elapsed_ff, elapsed_in;

   logic             tick, byte_v;
   logic [16:0]      elapsed_inc, limit_sum;
   logic [10:0]      cap_eff, to_read;
   logic             is_digit;
   logic [19:0]      acc_next;
   logic [4:0][7:0]  window_shift;
   logic [2:0]       fill_next;
   logic             hdr_match;
   logic [16:0]      cons_inc;
   logic             cons_done;
   logic [10:0]      dlv_inc;

   logic hunt_timeout, len_end, len_bad, len_ovf, len_digit_ok, len_error;
   logic begin_go, zero_len, tick_expire, pay_to_disc, pay_byte, disc_byte;
   logic disc_done, restart;

   // decode
   assign tick        = step_valid && (step_cmd == CMD_TICK);
   assign byte_v      = step_valid && (step_cmd == CMD_BYTE);
   assign elapsed_inc = (elapsed_ff < ELAPSED_MAX) ? elapsed_ff + 17'd1 : elapsed_ff;
   assign limit_sum   = {1'b0, cfg.timeout_ticks} + {1'b0, cfg.grace_ticks};

   assign cap_eff = ({6'b0, cfg.capacity} > MAX_CAP_W) ? MAX_CAP_W[10:0] : cfg.capacity;
   assign to_read = ({5'b0, cap_eff} < length_accum_ff) ? cap_eff : length_accum_ff[10:0];

   assign is_digit = (step_byte >= CHAR_ZERO) && (step_byte <= CHAR_NINE);
   assign acc_next = 20'({length_accum_ff, 3'b000}) + 20'({length_accum_ff, 1'b0})
                   + 20'(step_byte - CHAR_ZERO);

   // newest byte at the top; compared only once five bytes are in
   assign window_shift = {step_byte, window_ff[4:1]};
   assign fill_next    = (window_fill_ff == WINDOW_LEN) ? WINDOW_LEN : window_fill_ff + 3'd1;
   assign hdr_match    = (fill_next == WINDOW_LEN) && (window_shift == HDR_PATTERN);

   assign cons_inc  = {1'b0, consumed_ff} + 17'd1;
   assign cons_done = cons_inc >= {1'b0, length_accum_ff};
   assign dlv_inc   = delivered_ff + 11'd1;

   assign hunt_timeout = tick && (phase_ff == PH_HUNT)
                       && (elapsed_inc >= {1'b0, cfg.timeout_ticks});
   assign len_end      = (phase_ff == PH_LEN)
                       && ((tick && (elapsed_inc >= {1'b0, cfg.grace_ticks}))
                           || (byte_v && (step_byte == CHAR_COLON)));
   assign len_bad      = byte_v && (phase_ff == PH_LEN) && (step_byte != CHAR_COLON)
                       && !is_digit;
   assign len_ovf      = byte_v && (phase_ff == PH_LEN) && is_digit && (acc_next > LENGTH_MAX);
   assign len_digit_ok = byte_v && (phase_ff == PH_LEN) && is_digit && !(acc_next > LENGTH_MAX);
   assign len_error    = len_bad || len_ovf || (len_end && !digit_seen_ff);
   assign begin_go     = len_end && digit_seen_ff;
   assign zero_len     = begin_go && (length_accum_ff == 16'd0);
   assign tick_expire  = tick && ((phase_ff == PH_PAY) || (phase_ff == PH_DISC))
                       && (elapsed_inc >= limit_sum);
   assign pay_to_disc  = tick && (phase_ff == PH_PAY) && !tick_expire
                       && (elapsed_inc >= {1'b0, cfg.timeout_ticks});
   assign pay_byte     = byte_v && (phase_ff == PH_PAY);
   assign disc_byte    = byte_v && (phase_ff == PH_DISC);
   assign disc_done    = disc_byte && cons_done;
   assign restart      = hunt_timeout || len_error || zero_len || tick_expire
                       || (pay_byte && cons_done) || disc_done;

   // next state
   always_comb begin
      phase_in        = phase_ff;
      window_in       = window_ff;
      window_fill_in  = window_fill_ff;
      length_accum_in = length_accum_ff;
      digit_seen_in   = digit_seen_ff;
      consumed_in     = consumed_ff;
      delivered_in    = delivered_ff;
      elapsed_in      = tick ? elapsed_inc : elapsed_ff;
      case (phase_ff)
         PH_HUNT: begin
            if (byte_v) begin
               window_in      = window_shift;
               window_fill_in = fill_next;
               if (hdr_match) begin
                  phase_in        = PH_LEN;
                  length_accum_in = 16'd0;
                  digit_seen_in   = 1'b0;
                  elapsed_in      = 17'd0;
               end
            end
         end
         PH_LEN: begin
            if (len_digit_ok) begin
               length_accum_in = acc_next[15:0];
               digit_seen_in   = 1'b1;
            end
            if (begin_go) begin
               consumed_in  = 16'd0;
               delivered_in = 11'd0;
               elapsed_in   = 17'd0;
               phase_in     = (cap_eff == 11'd0) ? PH_DISC : PH_PAY;
            end
         end
         PH_PAY: begin
            if (pay_to_disc) begin
               phase_in = PH_DISC;
            end
            if (pay_byte) begin
               consumed_in  = cons_inc[15:0];
               delivered_in = dlv_inc;
               if (dlv_inc >= to_read) begin
                  phase_in = PH_DISC;
               end
            end
         end
         PH_DISC: begin
            if (disc_byte) begin
               consumed_in = cons_inc[15:0];
            end
         end
         default: phase_in = PH_HUNT;
      endcase
      // back to the header hunt
      if (restart) begin
         phase_in       = PH_HUNT;
         window_fill_in = 3'd0;
         elapsed_in     = 17'd0;
      end
   end

   // result
   always_comb begin
      res           = '0;
      res.kind      = KIND_PAYLOAD;
      if (hunt_timeout) begin
         res.valid = 1'b1;
         res.kind  = KIND_HDR_TIMEOUT;
      end else if (len_error) begin
         res.valid = 1'b1;
         res.kind  = KIND_PROTO_ERR;
      end else if (zero_len) begin
         res.valid     = 1'b1;
         res.kind      = KIND_FRAME_END;
         res.frame_end = 1'b1;
      end else if (tick_expire || disc_done) begin
         res.valid     = 1'b1;
         res.kind      = KIND_FRAME_END;
         res.frame_end = 1'b1;
         res.delivered = delivered_ff;
      end else if (pay_byte) begin
         res.valid     = 1'b1;
         res.kind      = KIND_PAYLOAD;
         res.data      = step_byte;
         res.frame_end = cons_done;
         res.delivered = dlv_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         window_fill_ff  <= 3'd0;
         length_accum_ff <= 16'd0;
         digit_seen_ff   <= 1'b0;
         consumed_ff     <= 16'd0;
         delivered_ff    <= 11'd0;
         elapsed_ff      <= 17'd0;
      end else begin
         phase_ff        <= phase_in;
         window_fill_ff  <= window_fill_in;
         length_accum_ff <= length_accum_in;
         digit_seen_ff   <= digit_seen_in;
         consumed_ff     <= consumed_in;
         delivered_ff    <= delivered_in;
         elapsed_ff      <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      window_fill_ff <= WINDOW_LEN)
      else $error("header window fill out of range");

   a_len_entry: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEN && $past(phase_ff) == PH_HUNT)
         |-> ($past(window_fill_ff) >= 3'd4 && $past(step_valid)
              && $past(step_cmd) == CMD_BYTE))
      else $error("length phase entered without a full header window");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY || phase_ff == PH_DISC) |-> length_accum_ff != 16'd0)
      else $error("payload phase with zero length");

   a_consumed: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY || phase_ff == PH_DISC) |-> consumed_ff < length_accum_ff)
      else $error("payload count reached length without frame end");

endmodule
